[rtl/core/ip_range_classifier_unit_assert.svh]
// Assertion macros shared by the range classifier RTL.
`ifndef IP_RANGE_CLASSIFIER_UNIT_ASSERT_SVH
`define IP_RANGE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iprc assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define IPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iprc assertion failed (next cycle)");

`endif

[rtl/core/iprc_pkg.sv]
// Types and constants shared by the range classifier modules.
`default_nettype none

package iprc_pkg;

    // Action codes carried on the input transaction.
    localparam logic [1:0] ACT_EXPLICIT = 2'd0;
    localparam logic [1:0] ACT_PREFIX   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;

    typedef enum logic [2:0] {
        ST_MATCHED = 3'd0,
        ST_DEFAULT = 3'd1,
        ST_DROPPED = 3'd2,
        ST_STORED  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // One stored range.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] last;
        logic [3:0]  dest;
    } t_entry;

    // Outcome of a table scan, as seen by the sequencer.
    typedef struct packed {
        logic       found;
        logic       in_range;
        logic [3:0] route;
        logic       hit;
    } t_scan_res;

endpackage

`default_nettype wire

[rtl/core/iprc_table.sv]
// Range table storage: one write port and one registered read port.
`default_nettype none

module iprc_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire iprc_pkg::t_entry      i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    output iprc_pkg::t_entry           o_rd_data
);

    iprc_pkg::t_entry r_mem [DEPTH];
    iprc_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/iprc_scan.sv]
// Shared compare unit that walks table entries one per cycle.
`default_nettype none

module iprc_scan #(
    parameter int AW = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic                  i_lookup,
    input  wire logic [31:0]           i_key,
    input  wire logic                  i_pend,
    input  wire logic [AW-1:0]         i_pend_idx,
    input  wire iprc_pkg::t_entry      i_entry,
    output iprc_pkg::t_scan_res        o_res,
    output logic [AW-1:0]              o_hit_idx
);

    logic          r_found, n_found;
    logic [31:0]   r_best_start, n_best_start;
    logic [31:0]   r_best_last, n_best_last;
    logic [3:0]    r_best_dest, n_best_dest;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;

    always_comb begin
        n_found      = r_found;
        n_best_start = r_best_start;
        n_best_last  = r_best_last;
        n_best_dest  = r_best_dest;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        if (i_clear) begin
            n_found = 1'b0;
            n_hit   = 1'b0;
        end else if (i_pend) begin
            if (i_lookup) begin
                // Greatest start not above the key; the first of equals wins.
                if ((i_entry.start <= i_key) &&
                    (!r_found || (i_entry.start > r_best_start))) begin
                    n_found      = 1'b1;
                    n_best_start = i_entry.start;
                    n_best_last  = i_entry.last;
                    n_best_dest  = i_entry.dest;
                end
            end else if ((i_entry.start == i_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = i_pend_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_found <= n_found;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_start <= n_best_start;
        r_best_last  <= n_best_last;
        r_best_dest  <= n_best_dest;
        r_hit_idx    <= n_hit_idx;
    end

    assign o_res.found    = r_found;
    assign o_res.in_range = (i_key <= r_best_last);
    assign o_res.route    = r_best_dest;
    assign o_res.hit      = r_hit;
    assign o_hit_idx      = r_hit_idx;

endmodule

`default_nettype wire

[rtl/core/ip_range_classifier_unit.sv]
// Top level of the IPv4 address range classifier.
// Usage: one input transaction carries an action (explicit insert, prefix insert or lookup),
// an address, a range end, a prefix length and a destination. Each input transaction gives
// exactly one output transaction with a status and a route.
// Both channels use valid and stall; a transaction completes on a clock edge with valid high
// and stall low. The input stall is high while an item is being worked on.
// An item with a zero address skips the scan and goes straight to the commit step.
// Any other item walks the filled part of the table, one entry per cycle through the single
// table read port and the shared compare unit, then commits its result. One item is in work
// at a time and the sequencer returns to idle before it takes the next, so a new item is
// taken only once the last one has committed its result.
// Reset (synchronous, active low) empties the table at once by clearing its fill count and
// drops any result that has not been taken. No clearing pass is needed.
// While the receiver stalls, the finished result is held in the output register and a new
// item is still accepted; that item waits at its final step until the register is free.
`default_nettype none

`include "ip_range_classifier_unit_assert.svh"

module ip_range_classifier_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int DESTINATIONS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_range_last,
    input  wire logic [5:0]  i_prefix_length,
    input  wire logic [3:0]  i_destination,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_route
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CntMax    = CW'(TABLE_ENTRIES);
    localparam logic [8:0]    DestLimit = 9'(DESTINATIONS);
    localparam logic [3:0]    DestSat   = 4'(DESTINATIONS - 1);

    iprc_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend;
    logic [AW-1:0]       r_pend_idx;
    logic [CW-1:0]       r_count, n_count;
    logic                r_lookup, r_zero;
    logic [31:0]         r_addr, r_last;
    logic [3:0]          r_dest;
    logic                r_out_valid, n_out_valid;
    iprc_pkg::t_status   r_status, n_status;
    logic [3:0]          r_route, n_route;

    logic                accept;
    logic                rd_en;
    logic                out_free;
    logic                load;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    iprc_pkg::t_entry    wr_data;
    iprc_pkg::t_entry    rd_data;
    iprc_pkg::t_scan_res scan_res;
    logic [AW-1:0]       hit_idx;
    logic                in_lookup;
    logic [31:0]         in_last;
    logic [3:0]          in_dest;

    // An input transaction completes whenever the sequencer is idle.
    assign o_in_stall = (r_state != iprc_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // Action code three behaves as a lookup.
    assign in_lookup = !((i_action == iprc_pkg::ACT_EXPLICIT) ||
                         (i_action == iprc_pkg::ACT_PREFIX));

    // A prefix range ends at start + 2^(32 - len) - 1, modulo 2^32. Shifting the all-ones
    // mask gives the size less one directly, and lengths of 32 and above shift it to zero.
    assign in_last = (i_action == iprc_pkg::ACT_PREFIX)
                   ? (i_address + (32'hFFFF_FFFF >> i_prefix_length))
                   : i_range_last;

    // Destinations beyond the configured count saturate to the highest one.
    assign in_dest = ({5'd0, i_destination} >= DestLimit) ? DestSat : i_destination;

    // One table entry is read per cycle while scanning the filled part of the table.
    assign rd_en = (r_state == iprc_pkg::S_SCAN) && (r_idx < r_count);

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = (r_state == iprc_pkg::S_COMMIT) && out_free;

    // Inserts overwrite the entry with the same start, else take the next free slot.
    // Slots are never freed, so the valid entries are always the first r_count ones.
    assign wr_en   = load && !r_zero && !r_lookup && (scan_res.hit || (r_count < CntMax));
    assign wr_addr = scan_res.hit ? hit_idx : r_count[AW-1:0];
    assign wr_data = '{start: r_addr, last: r_last, dest: r_dest};

    iprc_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    iprc_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept),
        .i_lookup   (r_lookup),
        .i_key      (r_addr),
        .i_pend     (r_pend),
        .i_pend_idx (r_pend_idx),
        .i_entry    (rd_data),
        .o_res      (scan_res),
        .o_hit_idx  (hit_idx)
    );

    // Sequencer: idle, scan the table (skipped for a zero address), then commit the result and any table write.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_route     = r_route;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            iprc_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    // A zero address needs no scan: lookups drop, inserts are not kept.
                    n_state = (i_address == 32'd0) ? iprc_pkg::S_COMMIT : iprc_pkg::S_SCAN;
                end
            end
            iprc_pkg::S_SCAN: begin
                if (rd_en) begin
                    n_idx = r_idx + CW'(1);
                end else if (!r_pend) begin
                    // Last read data has been compared; scan results are settled.
                    n_state = iprc_pkg::S_COMMIT;
                end
            end
            iprc_pkg::S_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_route     = 4'd0;
                    if (r_zero) begin
                        n_status = r_lookup ? iprc_pkg::ST_DROPPED : iprc_pkg::ST_STORED;
                    end else if (r_lookup) begin
                        if (scan_res.found && scan_res.in_range) begin
                            n_status = iprc_pkg::ST_MATCHED;
                            n_route  = scan_res.route;
                        end else begin
                            n_status = iprc_pkg::ST_DEFAULT;
                        end
                    end else if (scan_res.hit) begin
                        n_status = iprc_pkg::ST_STORED;
                    end else if (r_count < CntMax) begin
                        n_status = iprc_pkg::ST_STORED;
                        n_count  = r_count + CW'(1);
                    end else begin
                        n_status = iprc_pkg::ST_FULL;
                    end
                    n_state = iprc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iprc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iprc_pkg::S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= rd_en;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: item fields held for the whole scan, and the result.
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx[AW-1:0];
        r_status   <= n_status;
        r_route    <= n_route;
        if (accept) begin
            r_lookup <= in_lookup;
            r_zero   <= (i_address == 32'd0);
            r_addr   <= i_address;
            r_last   <= in_last;
            r_dest   <= in_dest;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_route     = r_route;

    // The fill count never passes the table size.
    `IPRC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntMax)

    // The table grows by at most one entry per cycle.
    `IPRC_ASSERT_IMPL(a_count_step, i_clk, i_rst_n, 1'b1,
        (r_count == $past(r_count)) || (r_count == ($past(r_count) + CW'(1))))

    // An accepted transaction always leaves the sequencer busy in the next cycle.
    `IPRC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, o_in_stall)

    // Only a match carries a route.
    `IPRC_ASSERT_IMPL(a_route_zero, i_clk, i_rst_n,
        o_out_valid && (o_status != iprc_pkg::ST_MATCHED), o_route == 4'd0)

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the IPv4 range classifier: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_ENTRIES = 64;
    localparam int DESTINATIONS  = 16;
    // The block treats the spare action code as a lookup.
    localparam logic [1:0] ACT_LOOKUP_ALT = 2'd3;
    localparam logic [5:0] PREFIX_MAX     = 6'd32;
    localparam int RANDOM_ITEMS  = 600;
    localparam int HOLD_AT_REPLY = 150;
    localparam int HOLD_CYCLES   = 300;

    // Routing-table scoreboard: mirrors the range table and queues the expected replies.
    class route_table_scoreboard;
        typedef struct packed {
            logic [2:0] status;
            logic [3:0] route;
        } t_reply;

        bit          used [TABLE_ENTRIES];
        logic [31:0] starts [TABLE_ENTRIES];
        logic [31:0] ends [TABLE_ENTRIES];
        logic [3:0]  dests [TABLE_ENTRIES];
        t_reply      expected_replies[$];
        int          failures;

        function new();
            failures = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // Stores a range. A zero start is reported as stored but is never kept,
        // so such a range never matches.
        function iprc_pkg::t_status store_range(logic [31:0] range_start,
                                                logic [31:0] range_end, logic [3:0] dest);
            int slot;
            int spare;
            slot  = -1;
            spare = -1;
            if (range_start == 32'd0) return iprc_pkg::ST_STORED;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (used[i]) begin
                    if (starts[i] == range_start && slot < 0) slot = i;
                end else if (spare < 0) begin
                    spare = i;
                end
            end
            if (slot < 0) slot = spare;
            if (slot < 0) return iprc_pkg::ST_FULL;
            used[slot]   = 1'b1;
            starts[slot] = range_start;
            ends[slot]   = range_end;
            dests[slot]  = dest;
            return iprc_pkg::ST_STORED;
        endfunction

        // The entry with the greatest start not above the address decides the route.
        function t_reply look_up_route(logic [31:0] addr);
            t_reply r;
            int best;
            r.status = iprc_pkg::ST_DEFAULT;
            r.route  = 4'd0;
            best     = -1;
            if (addr == 32'd0) begin
                r.status = iprc_pkg::ST_DROPPED;
                return r;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (used[i] && starts[i] <= addr) begin
                    if (best < 0 || starts[i] > starts[best]) best = i;
                end
            end
            if (best >= 0 && addr <= ends[best]) begin
                r.status = iprc_pkg::ST_MATCHED;
                r.route  = dests[best];
            end
            return r;
        endfunction

        function void note_request(logic [1:0] act, logic [31:0] addr, logic [31:0] range_end,
                                   logic [5:0] plen, logic [3:0] dest);
            t_reply      r;
            logic [5:0]  len;
            logic [63:0] span;
            logic [3:0]  d;
            r.route = 4'd0;
            d = (int'(dest) >= DESTINATIONS) ? 4'(DESTINATIONS - 1) : dest;
            if (act == iprc_pkg::ACT_EXPLICIT) begin
                r.status = store_range(addr, range_end, d);
            end else if (act == iprc_pkg::ACT_PREFIX) begin
                len  = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
                // A length of zero spans all 2^32 addresses, so the end wraps to start - 1.
                span = 64'd1 << (PREFIX_MAX - len);
                r.status = store_range(addr, 32'({32'd0, addr} + span - 64'd1), d);
            end else begin
                r = look_up_route(addr);
            end
            expected_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            failures++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_reply(logic [2:0] status, logic [3:0] route);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("reply status %0d route %0d with nothing outstanding",
                                          status, route));
                return;
            end
            want = expected_replies.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (route !== want.route)
                report_mismatch($sformatf("route %0d, expected %0d", route, want.route));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [31:0] i_address;
    logic [31:0] i_range_last;
    logic [5:0]  i_prefix_length;
    logic [3:0]  i_destination;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_route;

    route_table_scoreboard sb;
    logic [31:0] issued_starts[$];
    bit          steady_sender;

    ip_range_classifier_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DESTINATIONS  (DESTINATIONS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_range_last    (i_range_last),
        .i_prefix_length (i_prefix_length),
        .i_destination   (i_destination),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_route         (o_route)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Both transactions are sampled at the edge with the values that were
    // settled before it, so the order of processes within the step is irrelevant.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_reply(o_status, o_route);
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_action, i_address, i_range_last, i_prefix_length,
                                i_destination);
        end
    end

    // Offers one transaction, after an optional random gap, and returns at the edge
    // where it is taken. The payload stays put while the block stalls.
    task automatic send_item(input logic [1:0] act, input logic [31:0] addr,
                             input logic [31:0] range_end, input logic [5:0] plen,
                             input logic [3:0] dest);
        while (!steady_sender && $urandom_range(0, 99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_address       <= addr;
        i_range_last    <= range_end;
        i_prefix_length <= plen;
        i_destination   <= dest;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Lets the block run dry: nothing is offered until every reply has come back.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random traffic. Starts are remembered so that later inserts can overwrite them
    // and lookups can land in and just around stored ranges.
    task automatic send_random_item();
        int          kind;
        int          pick;
        logic [1:0]  act;
        logic [31:0] addr;
        logic [31:0] range_end;
        logic [5:0]  plen;
        logic [3:0]  dest;
        kind      = $urandom_range(0, 99);
        pick      = $urandom_range(0, 99);
        range_end = $urandom();
        dest      = 4'($urandom_range(0, 15));
        plen      = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(8, 32));
        if (kind < 45) begin
            act = (kind < 25) ? iprc_pkg::ACT_EXPLICIT : iprc_pkg::ACT_PREFIX;
            if (pick < 35 && issued_starts.size() > 0) begin
                addr = issued_starts[$urandom_range(0, issued_starts.size() - 1)];
            end else if (pick < 40) begin
                addr = 32'd0;
            end else begin
                addr = $urandom();
                issued_starts.push_back(addr);
            end
            // Mostly short well-formed ranges; the rest keep a random end, often below the start.
            if (act == iprc_pkg::ACT_EXPLICIT && $urandom_range(0, 3) != 0)
                range_end = addr + 32'($urandom_range(0, 4095));
        end else begin
            act = ($urandom_range(0, 9) == 0) ? ACT_LOOKUP_ALT : iprc_pkg::ACT_LOOKUP;
            if (pick < 70 && issued_starts.size() > 0)
                addr = issued_starts[$urandom_range(0, issued_starts.size() - 1)]
                       + 32'($urandom_range(0, 5000)) - 32'd2;
            else if (pick < 75)
                addr = 32'd0;
            else if (pick < 80)
                addr = 32'hFFFF_FFFF;
            else
                addr = $urandom();
        end
        send_item(act, addr, range_end, plen, dest);
    endtask

    // Receiver: random stalls, one long hold-off that backs the block up into its
    // input, and a window of replies taken without any stall.
    initial begin
        int  replies_taken;
        int  hold_left;
        bit  held;
        replies_taken = 0;
        hold_left     = 0;
        held          = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) replies_taken++;
            if (!held && replies_taken >= HOLD_AT_REPLY) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (replies_taken >= 300 && replies_taken < 400) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 32);
            end
        end
    end

    initial begin
        sb            = new();
        steady_sender = 1'b0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= iprc_pkg::ACT_EXPLICIT;
        i_address       <= 32'd0;
        i_range_last    <= 32'd0;
        i_prefix_length <= 6'd0;
        i_destination   <= 4'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: a zero address is dropped, anything else takes the default.
        send_item(iprc_pkg::ACT_LOOKUP, 32'd0, 32'hFFFF_FFFF, 6'd63, 4'd15);
        send_item(iprc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 6'd0, 4'd0);
        send_item(ACT_LOOKUP_ALT, 32'd1, 32'd0, 6'd0, 4'd0);
        // A range from zero is acknowledged but can never match.
        send_item(iprc_pkg::ACT_EXPLICIT, 32'd0, 32'hFFFF_FFFF, 6'd0, 4'd5);
        send_item(iprc_pkg::ACT_LOOKUP, 32'd5, 32'd0, 6'd0, 4'd0);
        // Plain explicit range, hit inside and misses just outside both ends.
        send_item(iprc_pkg::ACT_EXPLICIT, 32'h0A00_0000, 32'h0AFF_FFFF, 6'd0, 4'd1);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h0A12_3456, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h0B00_0000, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h09FF_FFFF, 32'd0, 6'd0, 4'd0);
        // An end below the start is stored but never matches.
        send_item(iprc_pkg::ACT_EXPLICIT, 32'h2000_0000, 32'h1000_0000, 6'd0, 4'd2);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h2000_0000, 32'd0, 6'd0, 4'd0);
        // A /16 prefix, hit at its top address, miss one above.
        send_item(iprc_pkg::ACT_PREFIX, 32'hC0A8_0000, 32'd0, 6'd16, 4'd15);
        send_item(iprc_pkg::ACT_LOOKUP, 32'hC0A8_FFFF, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_LOOKUP, 32'hC0A9_0000, 32'd0, 6'd0, 4'd0);
        // A single address at the very top of the space.
        send_item(iprc_pkg::ACT_PREFIX, 32'hFFFF_FFFF, 32'd0, 6'd32, 4'd7);
        send_item(iprc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 6'd0, 4'd0);
        // A length above 32 is clamped to a single address.
        send_item(iprc_pkg::ACT_PREFIX, 32'h3000_0000, 32'h3FFF_FFFF, 6'd63, 4'd3);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h3000_0001, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h3000_0000, 32'd0, 6'd0, 4'd0);
        // A length of zero wraps the end to start - 1, so off zero it never matches.
        send_item(iprc_pkg::ACT_PREFIX, 32'h4000_0000, 32'd0, 6'd0, 4'd9);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h4000_0001, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_PREFIX, 32'd0, 32'd0, 6'd0, 4'd4);
        // Overwriting an existing start narrows the range and changes the route.
        send_item(iprc_pkg::ACT_EXPLICIT, 32'h0A00_0000, 32'h0A00_00FF, 6'd0, 4'd12);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h0A00_0100, 32'd0, 6'd0, 4'd0);
        send_item(iprc_pkg::ACT_LOOKUP, 32'h0A00_0080, 32'd0, 6'd0, 4'd0);
        drain_replies();

        // Random part; the table fills up along the way, so full-table rejects follow.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_sender = (n >= 300 && n < 400);
            if (n == 450) drain_replies();
            send_random_item();
        end
        steady_sender = 1'b0;
        drain_replies();
        // Room for a stray late reply to show up before the verdict.
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
